FILE: rtl/core/mi3_pkg.sv
package mi3_pkg;

  // Element format and derived datapath widths.
  localparam int EW    = 32;              // element width
  localparam int FB    = 16;              // fractional bits
  localparam int CW    = 2 * EW + 1;      // cofactor width, signed
  localparam int NUM_W = CW + 2 * FB;     // shifted numerator magnitude
  localparam int DET_W = EW + CW + 2;     // determinant width, signed
  localparam int LO_W  = EW + 1;          // low slice of a cofactor in the det multiply
  localparam int HI_W  = CW - LO_W;       // high slice, signed
  localparam int TW    = DET_W + EW;      // trial subtract width in the divider

  // Pipeline stage numbers.
  localparam int S_PROD = 1;
  localparam int S_ADJ  = 2;
  localparam int S_PP   = 3;
  localparam int S_TERM = 4;
  localparam int S_SUM  = 5;
  localparam int S_DET  = 6;
  localparam int S_INIT = 7;
  localparam int S_SAT  = S_INIT + EW + 1;
  localparam int S_OUT  = S_SAT + 1;
  localparam int NSTG   = S_OUT;

  typedef logic signed [EW-1:0]  elem_t;
  typedef logic signed [CW-1:0]  cof_t;
  typedef logic [DET_W-1:0]      dmag_t;
  typedef logic [NSTG:1]         ld_t;
  typedef logic [EW:0][DET_W-1:0] dline_t;

  // Result of one lane after saturation.
  typedef struct packed {
    logic  ovf;
    elem_t val;
  } lane_res_t;

  // Adjugate element k = m[p]*m[q] - m[r]*m[s].
  localparam int ADJ_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

endpackage

FILE: rtl/core/mi3_lane.sv
module mi3_lane import mi3_pkg::*; (
  input  logic      clk,
  input  ld_t       ld,
  input  elem_t     ma,
  input  elem_t     mb,
  input  elem_t     mc,
  input  elem_t     md,
  input  dline_t    dline,
  input  logic      dneg,
  output cof_t      adj_o,
  output lane_res_t res_o
);

  logic signed [2*EW-1:0] p1_r, p2_r;
  cof_t                   adj_r;
  logic [NUM_W-1:0]       num_r [S_PP:S_DET];
  logic                   nneg_r [S_PP:S_DET];
  logic [NUM_W-1:0]       rem_r [0:EW];
  logic [EW-1:0]          q_r   [0:EW];
  logic                   neg_r [0:EW];
  logic                   big_r [0:EW];
  lane_res_t              res_r;
  logic [TW:0]            big_t;
  cof_t                   mag;

  // Cofactor products and their difference.
  always_ff @(posedge clk) begin
    if (ld[S_PROD]) begin
      p1_r <= ma * mb;
      p2_r <= mc * md;
    end
    if (ld[S_ADJ]) begin
      adj_r <= CW'(p1_r) - CW'(p2_r);
    end
  end
  assign adj_o = adj_r;

  // Numerator magnitude, scaled to the output format.
  assign mag = adj_r[CW-1] ? -adj_r : adj_r;

  always_ff @(posedge clk) begin
    if (ld[S_PP]) begin
      num_r[S_PP]  <= {mag, (2*FB)'(0)};
      nneg_r[S_PP] <= adj_r[CW-1];
    end
    for (int s = S_PP + 1; s <= S_DET; s++) begin
      if (ld[s]) begin
        num_r[s]  <= num_r[s-1];
        nneg_r[s] <= nneg_r[s-1];
      end
    end
  end

  // A quotient of 2^EW or more saturates in any case.
  assign big_t = {(TW + 1 - NUM_W)'(0), num_r[S_DET]}
               - ({1'b0, TW'(dline[0])} << EW);

  always_ff @(posedge clk) begin
    if (ld[S_INIT]) begin
      rem_r[0] <= num_r[S_DET];
      q_r[0]   <= '0;
      neg_r[0] <= nneg_r[S_DET] ^ dneg;
      big_r[0] <= ~big_t[TW];
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar i = 0; i < EW; i++) begin : g_step
    localparam int B = EW - 1 - i;
    logic [TW:0]   t;
    logic [EW-1:0] q_nxt;

    always_comb begin
      t        = {(TW + 1 - NUM_W)'(0), rem_r[i]} - ({1'b0, TW'(dline[i+1])} << B);
      q_nxt    = q_r[i];
      q_nxt[B] = ~t[TW];
    end

    always_ff @(posedge clk) begin
      if (ld[S_INIT + 1 + i]) begin
        rem_r[i+1] <= t[TW] ? rem_r[i] : t[NUM_W-1:0];
        q_r[i+1]   <= q_nxt;
        neg_r[i+1] <= neg_r[i];
        big_r[i+1] <= big_r[i];
      end
    end
  end

  // Sign and saturation.
  always_ff @(posedge clk) begin
    if (ld[S_SAT]) begin
      if (neg_r[EW]) begin
        if (big_r[EW] || (q_r[EW][EW-1] && (|q_r[EW][EW-2:0]))) begin
          res_r.val <= {1'b1, (EW-1)'(0)};
          res_r.ovf <= 1'b1;
        end else begin
          res_r.val <= -$signed(q_r[EW]);
          res_r.ovf <= 1'b0;
        end
      end else begin
        if (big_r[EW] || q_r[EW][EW-1]) begin
          res_r.val <= {1'b0, {(EW-1){1'b1}}};
          res_r.ovf <= 1'b1;
        end else begin
          res_r.val <= $signed(q_r[EW]);
          res_r.ovf <= 1'b0;
        end
      end
    end
  end
  assign res_o = res_r;

endmodule

FILE: rtl/core/mi3_det.sv
module mi3_det import mi3_pkg::*; (
  input  logic   clk,
  input  ld_t    ld,
  input  elem_t  m0,
  input  elem_t  m1,
  input  elem_t  m2,
  input  cof_t   adj0,
  input  cof_t   adj3,
  input  cof_t   adj6,
  output dline_t dline,
  output logic   dneg,
  output logic   zero
);

  elem_t                    a1_r [3];
  elem_t                    a2_r [3];
  cof_t                     c [3];
  logic signed [2*EW-1:0]   ph_r [3];
  logic signed [2*EW+1:0]   pl_r [3];
  logic signed [DET_W-1:0]  term_r [3];
  logic signed [DET_W-1:0]  det_r;
  dline_t                   dline_r;
  logic                     dneg_r;
  logic                     zero_r [0:S_SAT-S_DET];

  assign c[0] = adj0;
  assign c[1] = adj3;
  assign c[2] = adj6;

  // First row held until its cofactors are ready.
  always_ff @(posedge clk) begin
    if (ld[S_PROD]) begin
      a1_r[0] <= m0;
      a1_r[1] <= m1;
      a1_r[2] <= m2;
    end
    if (ld[S_ADJ]) begin
      a2_r <= a1_r;
    end
  end

  // Split multiply of an element by a cofactor, then the expansion sum.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (ld[S_PP]) begin
        ph_r[k] <= a2_r[k] * $signed(c[k][CW-1:LO_W]);
        pl_r[k] <= a2_r[k] * $signed({1'b0, c[k][LO_W-1:0]});
      end
      if (ld[S_TERM]) begin
        term_r[k] <= (DET_W'(ph_r[k]) <<< LO_W) + DET_W'(pl_r[k]);
      end
    end
    if (ld[S_SUM]) begin
      det_r <= term_r[0] + term_r[1] + term_r[2];
    end
  end

  // Magnitude and zero flag, carried along the divider stages; the sign flag is registered once.
  always_ff @(posedge clk) begin
    if (ld[S_DET]) begin
      dline_r[0] <= det_r[DET_W-1] ? dmag_t'(-det_r) : dmag_t'(det_r);
      dneg_r     <= det_r[DET_W-1];
      zero_r[0]  <= (det_r == '0);
    end
    for (int j = 1; j <= EW; j++) begin
      if (ld[S_DET + j]) begin
        dline_r[j] <= dline_r[j-1];
      end
    end
    for (int j = 1; j <= S_SAT - S_DET; j++) begin
      if (ld[S_DET + j]) begin
        zero_r[j] <= zero_r[j-1];
      end
    end
  end

  assign dline = dline_r;
  assign dneg  = dneg_r;
  assign zero  = zero_r[S_SAT-S_DET];

endmodule

FILE: rtl/core/mi3_merge.sv
module mi3_merge import mi3_pkg::*; (
  input  logic      clk,
  input  ld_t       ld,
  input  lane_res_t res [9],
  input  logic      zero,
  output elem_t     inv [9],
  output logic      singular,
  output logic      overflow
);

  elem_t inv_r [9];
  logic  singular_r;
  logic  overflow_r;
  logic  any_ovf;

  // Any lane that saturated flags the whole matrix.
  always_comb begin
    any_ovf = 1'b0;
    for (int k = 0; k < 9; k++) begin
      any_ovf = any_ovf | res[k].ovf;
    end
  end

  // A singular matrix gives all-zero elements.
  always_ff @(posedge clk) begin
    if (ld[S_OUT]) begin
      for (int k = 0; k < 9; k++) begin
        inv_r[k] <= zero ? elem_t'(0) : res[k].val;
      end
      singular_r <= zero;
      overflow_r <= ~zero & any_ovf;
    end
  end

  assign inv      = inv_r;
  assign singular = singular_r;
  assign overflow = overflow_r;

endmodule

FILE: rtl/core/matrix_inverse_3x3_core.sv
// 3x3 fixed-point matrix inverse by adjugate and determinant.
// Throughput: one matrix per cycle while the output is not stalled; each lane has a 32-stage restoring divider.
// Stages advance independently, so bubbles collapse while the output is stalled.
// Reset (rst_n low, synchronous) clears every stage valid bit; datapath is not reset.
module matrix_inverse_3x3_core import mi3_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  elem_t in_m00,
  input  elem_t in_m01,
  input  elem_t in_m02,
  input  elem_t in_m10,
  input  elem_t in_m11,
  input  elem_t in_m12,
  input  elem_t in_m20,
  input  elem_t in_m21,
  input  elem_t in_m22,
  output logic  out_valid,
  input  logic  out_stall,
  output elem_t out_inv00,
  output elem_t out_inv01,
  output elem_t out_inv02,
  output elem_t out_inv10,
  output elem_t out_inv11,
  output elem_t out_inv12,
  output elem_t out_inv20,
  output elem_t out_inv21,
  output elem_t out_inv22,
  output logic  out_singular,
  output logic  out_overflow
);

  elem_t         m [9];
  cof_t          adj [9];
  lane_res_t     res [9];
  elem_t         inv [9];
  dline_t        dline;
  logic          dneg;
  logic          zero;
  logic [NSTG:1] v_r;
  logic [NSTG+1:1] ldx;
  ld_t           ld;

  assign m[0] = in_m00;
  assign m[1] = in_m01;
  assign m[2] = in_m02;
  assign m[3] = in_m10;
  assign m[4] = in_m11;
  assign m[5] = in_m12;
  assign m[6] = in_m20;
  assign m[7] = in_m21;
  assign m[8] = in_m22;

  // A stage loads when it is empty or its successor loads.
  always_comb begin
    ldx[NSTG+1] = ~out_stall;
    for (int s = NSTG; s >= 1; s--) begin
      ldx[s] = ~v_r[s] | ldx[s+1];
    end
  end
  assign ld       = ldx[NSTG:1];
  assign in_stall = ~ld[1];

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[1]) begin
        v_r[1] <= in_valid;
      end
      for (int s = 2; s <= NSTG; s++) begin
        if (ld[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end
  assign out_valid = v_r[NSTG];

  // One lane per inverse element.
  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_lane u_lane (
      .clk   (clk),
      .ld    (ld),
      .ma    (m[ADJ_IDX[k][0]]),
      .mb    (m[ADJ_IDX[k][1]]),
      .mc    (m[ADJ_IDX[k][2]]),
      .md    (m[ADJ_IDX[k][3]]),
      .dline (dline),
      .dneg  (dneg),
      .adj_o (adj[k]),
      .res_o (res[k])
    );
  end

  mi3_det u_det (
    .clk   (clk),
    .ld    (ld),
    .m0    (m[0]),
    .m1    (m[1]),
    .m2    (m[2]),
    .adj0  (adj[0]),
    .adj3  (adj[3]),
    .adj6  (adj[6]),
    .dline (dline),
    .dneg  (dneg),
    .zero  (zero)
  );

  mi3_merge u_merge (
    .clk      (clk),
    .ld       (ld),
    .res      (res),
    .zero     (zero),
    .inv      (inv),
    .singular (out_singular),
    .overflow (out_overflow)
  );

  assign out_inv00 = inv[0];
  assign out_inv01 = inv[1];
  assign out_inv02 = inv[2];
  assign out_inv10 = inv[3];
  assign out_inv11 = inv[4];
  assign out_inv12 = inv[5];
  assign out_inv20 = inv[6];
  assign out_inv21 = inv[7];
  assign out_inv22 = inv[8];

endmodule
